// ===== rtl/expression_tokenizer_assert.svh =====
// Assertion macros shared by the checker.
`ifndef EXPRESSION_TOKENIZER_ASSERT_SVH
`define EXPRESSION_TOKENIZER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define ET_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("expression_tokenizer check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define ET_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("expression_tokenizer check failed");

`endif

// ===== rtl/et_pkg.sv =====
`default_nettype none
package et_pkg;

	localparam int QueueDepth = 4;
	localparam int WordMax    = 5;

	localparam logic [2:0] KIND_NUMBER  = 3'd0;
	localparam logic [2:0] KIND_OPEN    = 3'd1;
	localparam logic [2:0] KIND_CLOSE   = 3'd2;
	localparam logic [2:0] KIND_OPER    = 3'd3;
	localparam logic [2:0] KIND_BOOL    = 3'd4;
	localparam logic [2:0] KIND_END     = 3'd5;
	localparam logic [2:0] KIND_BADWORD = 3'd6;
	localparam logic [2:0] KIND_BADSYM  = 3'd7;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [2:0] token_kind;
		logic [7:0] text_char;
		logic       token_last;
		logic       run_last;
	} out_item_t;

	// First part of a command: nothing, one result, or a whole boolean word.
	typedef enum logic [1:0] {
		PART_NONE,
		PART_SINGLE,
		PART_TRUE,
		PART_FALSE
	} part_t;

	// Work for the back end caused by one input item.
	typedef struct packed {
		part_t      part;
		logic [2:0] a_kind;
		logic [7:0] a_char;
		logic       a_last;
		logic       b_valid;
		logic [2:0] b_kind;
		logic [7:0] b_char;
	} cmd_t;

	function automatic logic [7:0] true_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0: ch = 8'h74;
			3'd1: ch = 8'h72;
			3'd2: ch = 8'h75;
			3'd3: ch = 8'h65;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] false_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0: ch = 8'h66;
			3'd1: ch = 8'h61;
			3'd2: ch = 8'h6c;
			3'd3: ch = 8'h73;
			3'd4: ch = 8'h65;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/et_front.sv =====
`default_nettype none
module et_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire et_pkg::in_item_t item,
	output et_pkg::cmd_t          cmd,
	output logic                  cmd_push
);

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_NUMBER,
		MODE_OPER,
		MODE_SIGN,
		MODE_WORD,
		MODE_DISCARD
	} mode_t;

	mode_t      mode_q, mode_d, st_mode;
	logic [7:0] held_q, held_d;
	logic [2:0] cnt_q, cnt_d;
	logic       long_q, long_d;
	logic [7:0] buf_q [et_pkg::WordMax];
	logic       buf_we;
	logic [2:0] buf_idx;

	logic [7:0] c;
	logic       is_space, is_digit, is_sign, is_op, is_letter, is_num;
	logic       st_emit, st_held, st_word;
	logic [2:0] st_kind;
	logic       use_start;
	logic       word_true, word_false;

	assign c = item.char_code;

	always_comb begin
		is_space  = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
		is_digit  = (c >= 8'h30) && (c <= 8'h39);
		is_sign   = (c == 8'h2b) || (c == 8'h2d);
		is_op     = is_sign || (c == 8'h2a) || (c == 8'h2f) || (c == 8'h5e) ||
			(c == 8'h3c) || (c == 8'h3e) || (c == 8'h3d) || (c == 8'h21) ||
			(c == 8'h26) || (c == 8'h7c);
		is_letter = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
		is_num    = is_digit || is_sign || (c == 8'h2e);
	end

	// Word match against the two boolean spellings.
	always_comb begin
		word_true  = !long_q && (cnt_q == 3'd4);
		word_false = !long_q && (cnt_q == 3'd5);
		for (int i = 0; i < 4; i++) begin
			if (buf_q[i] != et_pkg::true_char(3'(i))) word_true = 1'b0;
		end
		for (int i = 0; i < 5; i++) begin
			if (buf_q[i] != et_pkg::false_char(3'(i))) word_false = 1'b0;
		end
	end

	// Classify a character that opens a new token.
	always_comb begin
		st_mode = MODE_IDLE;
		st_emit = 1'b0;
		st_kind = et_pkg::KIND_BADSYM;
		st_held = 1'b0;
		st_word = 1'b0;
		if (is_space) begin
			st_mode = MODE_IDLE;
		end else if (is_digit) begin
			st_mode = MODE_NUMBER;
			st_held = 1'b1;
		end else if (is_sign) begin
			st_mode = MODE_SIGN;
			st_held = 1'b1;
		end else if (c == 8'h28) begin
			st_emit = 1'b1;
			st_kind = et_pkg::KIND_OPEN;
		end else if (c == 8'h29) begin
			st_emit = 1'b1;
			st_kind = et_pkg::KIND_CLOSE;
		end else if (is_op) begin
			st_mode = MODE_OPER;
			st_held = 1'b1;
		end else if (is_letter) begin
			st_mode = MODE_WORD;
			st_word = 1'b1;
		end else begin
			st_emit = 1'b1;
			st_mode = MODE_DISCARD;
		end
	end

	always_comb begin
		cmd       = '0;
		cmd.part  = et_pkg::PART_NONE;
		mode_d    = mode_q;
		held_d    = held_q;
		cnt_d     = cnt_q;
		long_d    = long_q;
		buf_we    = 1'b0;
		buf_idx   = cnt_q;
		use_start = 1'b0;
		if (item.end_of_text) begin
			cmd.b_valid = 1'b1;
			cmd.b_kind  = et_pkg::KIND_END;
			case (mode_q)
				MODE_NUMBER: begin
					cmd.part   = et_pkg::PART_SINGLE;
					cmd.a_kind = et_pkg::KIND_NUMBER;
					cmd.a_char = held_q;
					cmd.a_last = 1'b1;
				end
				MODE_OPER, MODE_SIGN: begin
					cmd.part   = et_pkg::PART_SINGLE;
					cmd.a_kind = et_pkg::KIND_OPER;
					cmd.a_char = held_q;
					cmd.a_last = 1'b1;
				end
				MODE_WORD: begin
					if (word_true) begin
						cmd.part = et_pkg::PART_TRUE;
					end else if (word_false) begin
						cmd.part = et_pkg::PART_FALSE;
					end else begin
						cmd.part    = et_pkg::PART_SINGLE;
						cmd.a_kind  = et_pkg::KIND_BADWORD;
						cmd.a_last  = 1'b1;
						cmd.b_valid = 1'b0;
					end
				end
				MODE_DISCARD: cmd.b_valid = 1'b0;
				default: cmd.b_valid = 1'b1;
			endcase
			mode_d = MODE_IDLE;
			cnt_d  = 3'd0;
			long_d = 1'b0;
		end else begin
			case (mode_q)
				MODE_NUMBER: begin
					cmd.part   = et_pkg::PART_SINGLE;
					cmd.a_kind = et_pkg::KIND_NUMBER;
					cmd.a_char = held_q;
					cmd.a_last = !is_num;
					if (is_num) held_d = c;
					else use_start = 1'b1;
				end
				MODE_OPER: begin
					cmd.part   = et_pkg::PART_SINGLE;
					cmd.a_kind = et_pkg::KIND_OPER;
					cmd.a_char = held_q;
					cmd.a_last = !is_op;
					if (is_op) held_d = c;
					else use_start = 1'b1;
				end
				MODE_SIGN: begin
					cmd.part   = et_pkg::PART_SINGLE;
					cmd.a_char = held_q;
					if (is_digit) begin
						cmd.a_kind = et_pkg::KIND_NUMBER;
						held_d     = c;
						mode_d     = MODE_NUMBER;
					end else if (is_op) begin
						cmd.a_kind = et_pkg::KIND_OPER;
						held_d     = c;
						mode_d     = MODE_OPER;
					end else begin
						cmd.a_kind = et_pkg::KIND_OPER;
						cmd.a_last = 1'b1;
						use_start  = 1'b1;
					end
				end
				MODE_WORD: begin
					if (is_letter) begin
						if (cnt_q < 3'(et_pkg::WordMax)) begin
							buf_we = 1'b1;
							cnt_d  = cnt_q + 3'd1;
						end else begin
							long_d = 1'b1;
						end
					end else if (word_true) begin
						cmd.part  = et_pkg::PART_TRUE;
						use_start = 1'b1;
					end else if (word_false) begin
						cmd.part  = et_pkg::PART_FALSE;
						use_start = 1'b1;
					end else begin
						cmd.part   = et_pkg::PART_SINGLE;
						cmd.a_kind = et_pkg::KIND_BADWORD;
						cmd.a_last = 1'b1;
						mode_d     = MODE_DISCARD;
					end
				end
				MODE_DISCARD: mode_d = MODE_DISCARD;
				default: use_start = 1'b1;
			endcase
			if (use_start) begin
				mode_d      = st_mode;
				cmd.b_valid = st_emit;
				cmd.b_kind  = st_kind;
				cmd.b_char  = c;
				if (st_held) held_d = c;
				if (st_word) begin
					buf_we  = 1'b1;
					buf_idx = 3'd0;
					cnt_d   = 3'd1;
					long_d  = 1'b0;
				end
			end
		end
	end

	assign cmd_push = accept && ((cmd.part != et_pkg::PART_NONE) || cmd.b_valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			held_q <= 8'd0;
			cnt_q  <= 3'd0;
			long_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			held_q <= held_d;
			cnt_q  <= cnt_d;
			long_q <= long_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && buf_we) buf_q[buf_idx] <= c;
	end

endmodule
`default_nettype wire

// ===== rtl/et_queue.sv =====
`default_nettype none
module et_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire et_pkg::cmd_t push_cmd,
	input  wire logic         pop,
	output logic              full,
	output logic              head_valid,
	output et_pkg::cmd_t      head_cmd
);

	localparam int PtrW = $clog2(et_pkg::QueueDepth);

	et_pkg::cmd_t  mem [et_pkg::QueueDepth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [PtrW:0]   cnt_q;

	assign full       = (cnt_q == (PtrW+1)'(et_pkg::QueueDepth));
	assign head_valid = (cnt_q != '0);
	assign head_cmd   = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/et_back.sv =====
`default_nettype none
module et_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	input  wire et_pkg::cmd_t      cmd,
	output logic                   cmd_pop,
	output logic                   tok_valid,
	input  wire logic              tok_stall,
	output et_pkg::out_item_t      tok_item
);

	logic [2:0]        idx_q;
	logic [2:0]        a_len, total, last_idx;
	logic              load, at_end;
	et_pkg::out_item_t res;
	logic              valid_q;
	et_pkg::out_item_t item_q;

	always_comb begin
		case (cmd.part)
			et_pkg::PART_SINGLE: a_len = 3'd1;
			et_pkg::PART_TRUE:   a_len = 3'd4;
			et_pkg::PART_FALSE:  a_len = 3'd5;
			default:             a_len = 3'd0;
		endcase
		total    = a_len + {2'b00, cmd.b_valid};
		last_idx = total - 3'd1;
		at_end   = (idx_q == last_idx);
	end

	// Pick the result at the current index of the head command.
	always_comb begin
		res.run_last = at_end;
		if (idx_q < a_len) begin
			if (cmd.part == et_pkg::PART_SINGLE) begin
				res.token_kind = cmd.a_kind;
				res.text_char  = cmd.a_char;
				res.token_last = cmd.a_last;
			end else begin
				res.token_kind = et_pkg::KIND_BOOL;
				res.text_char  = (cmd.part == et_pkg::PART_TRUE) ?
					et_pkg::true_char(idx_q) : et_pkg::false_char(idx_q);
				res.token_last = (idx_q == a_len - 3'd1);
			end
		end else begin
			res.token_kind = cmd.b_kind;
			res.text_char  = cmd.b_char;
			res.token_last = 1'b1;
		end
	end

	assign load    = cmd_valid && (!valid_q || !tok_stall);
	assign cmd_pop = load && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 3'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q   <= at_end ? 3'd0 : idx_q + 3'd1;
				valid_q <= 1'b1;
			end else if (!tok_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) item_q <= res;
	end

	assign tok_valid = valid_q;
	assign tok_item  = item_q;

endmodule
`default_nettype wire

// ===== rtl/expression_tokenizer.sv =====
// Channel   Direction  Handshake              Payload
// char      in         char_valid/char_stall  et_pkg::in_item_t  (char_code, end_of_text)
// tok       out        tok_valid/tok_stall    et_pkg::out_item_t (kind, char, last marks)
//
// One character item is taken per cycle while the command queue has room.
// Each item yields 0 to 6 results; the back end sends one result per cycle
// while the output is not stalled.
// A four-entry command queue lets the front keep taking items while the back end
// drains a longer burst such as a boolean word, and output stalls back up only
// once it fills.
// arst_n clears lexer mode, queue pointers and the output valid at once.
`default_nettype none
module expression_tokenizer (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              char_valid,
	output logic                   char_stall,
	input  wire et_pkg::in_item_t  char_item,
	output logic                   tok_valid,
	input  wire logic              tok_stall,
	output et_pkg::out_item_t      tok_item
);

	logic         accept;
	et_pkg::cmd_t front_cmd;
	logic         front_push;
	logic         q_full;
	logic         q_valid;
	et_pkg::cmd_t q_cmd;
	logic         q_pop;

	// Stall the input only when the queue cannot take another command.
	assign char_stall = q_full;
	assign accept     = char_valid && !q_full;

	// Front end: classify each item and advance the lexer state.
	et_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (char_item),
		.cmd      (front_cmd),
		.cmd_push (front_push)
	);

	// Hold commands between the two halves.
	et_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (front_push),
		.push_cmd   (front_cmd),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (q_valid),
		.head_cmd   (q_cmd)
	);

	// Back end: expand each command into result items, one per cycle while the output is not stalled.
	et_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (q_cmd),
		.cmd_pop   (q_pop),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_item  (tok_item)
	);

endmodule
`default_nettype wire

// ===== rtl/expression_tokenizer_chk.sv =====
`default_nettype none
`include "expression_tokenizer_assert.svh"
module expression_tokenizer_chk (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              char_valid,
	input  wire logic              char_stall,
	input  wire et_pkg::in_item_t  char_item,
	input  wire logic              tok_valid,
	input  wire logic              tok_stall,
	input  wire et_pkg::out_item_t tok_item
);

	logic single_kind;

	assign single_kind = (tok_item.token_kind == et_pkg::KIND_OPEN) ||
		(tok_item.token_kind == et_pkg::KIND_CLOSE) ||
		(tok_item.token_kind == et_pkg::KIND_END) ||
		(tok_item.token_kind == et_pkg::KIND_BADWORD) ||
		(tok_item.token_kind == et_pkg::KIND_BADSYM);

	`ET_ASSERT_NEXT(a_tok_hold, tok_valid && tok_stall, tok_valid && $stable(tok_item))
	`ET_ASSERT_NOW(a_single_last, tok_valid && single_kind, tok_item.token_last)
	`ET_ASSERT_NOW(a_end_final, tok_valid && (tok_item.token_kind == et_pkg::KIND_END), tok_item.run_last && (tok_item.text_char == 8'd0))
	`ET_ASSERT_NOW(a_bool_run, tok_valid && (tok_item.token_kind == et_pkg::KIND_BOOL) && !tok_item.token_last, !tok_item.run_last)

endmodule

bind expression_tokenizer expression_tokenizer_chk u_chk (.*);
`default_nettype wire

// ===== bench/token_checker.sv =====
`timescale 1ns / 100ps
module token_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              char_valid,
	input  wire logic              char_stall,
	input  wire et_pkg::in_item_t  char_item,
	input  wire logic              tok_valid,
	input  wire logic              tok_stall,
	input  wire et_pkg::out_item_t tok_item,
	output int                     fail_count,
	output int                     open_count
);
	import et_pkg::*;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_NUMBER,
		MODE_OPER,
		MODE_SIGN,
		MODE_WORD,
		MODE_DISCARD
	} lex_mode_t;

	lex_mode_t  mode;
	logic [7:0] held;
	logic [7:0] letters [WordMax];
	logic [2:0] nletters;
	logic       overlong;
	out_item_t  burst [$];
	out_item_t  expected_tokens [$];
	out_item_t  want;
	int         mismatches;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_op(input logic [7:0] c);
		return c == "+" || c == "-" || c == "*" || c == "/" || c == "^" || c == "<" ||
			c == ">" || c == "=" || c == "!" || c == "&" || c == "|";
	endfunction

	function automatic void add_token(input logic [2:0] kind, input logic [7:0] ch,
			input logic last);
		out_item_t r;
		if (burst.size() < 6) begin
			r.token_kind = kind;
			r.text_char  = ch;
			r.token_last = last;
			r.run_last   = 1'b0;
			burst.push_back(r);
		end
	endfunction

	// Character seen between tokens.
	function automatic void begin_token(input logic [7:0] c);
		mode = MODE_IDLE;
		if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) begin
			// whitespace only separates
		end else if (is_digit(c)) begin
			mode = MODE_NUMBER;
			held = c;
		end else if (c == "+" || c == "-") begin
			mode = MODE_SIGN;
			held = c;
		end else if (c == "(") begin
			add_token(KIND_OPEN, c, 1'b1);
		end else if (c == ")") begin
			add_token(KIND_CLOSE, c, 1'b1);
		end else if (is_op(c)) begin
			mode = MODE_OPER;
			held = c;
		end else if (is_letter(c)) begin
			mode        = MODE_WORD;
			letters[0]  = c;
			nletters    = 3'd1;
			overlong    = 1'b0;
		end else begin
			add_token(KIND_BADSYM, c, 1'b1);
			mode = MODE_DISCARD;
		end
	endfunction

	// Close the letter run; true when it was a boolean.
	function automatic logic close_word();
		logic good;
		good = !overlong &&
			((nletters == 3'd4 &&
			{letters[0], letters[1], letters[2], letters[3]} == "true") ||
			(nletters == 3'd5 &&
			{letters[0], letters[1], letters[2], letters[3], letters[4]} == "false"));
		if (!good) begin
			add_token(KIND_BADWORD, 8'h00, 1'b1);
			mode = MODE_DISCARD;
		end else begin
			for (int i = 0; i < int'(nletters); i++)
				add_token(KIND_BOOL, letters[i], i == int'(nletters) - 1);
			mode = MODE_IDLE;
		end
		return good;
	endfunction

	function automatic void predict_tokens(input in_item_t it);
		logic [7:0] c;
		logic       send_end;
		out_item_t  r;
		c = it.char_code;
		burst.delete();
		if (it.end_of_text) begin
			send_end = 1'b1;
			case (mode)
				MODE_NUMBER: add_token(KIND_NUMBER, held, 1'b1);
				MODE_OPER, MODE_SIGN: add_token(KIND_OPER, held, 1'b1);
				MODE_WORD: send_end = close_word();
				MODE_DISCARD: send_end = 1'b0;
				default: ;
			endcase
			if (send_end)
				add_token(KIND_END, 8'h00, 1'b1);
			mode     = MODE_IDLE;
			nletters = 3'd0;
			overlong = 1'b0;
		end else begin
			case (mode)
				MODE_NUMBER: begin
					if (is_digit(c) || c == "." || c == "+" || c == "-") begin
						add_token(KIND_NUMBER, held, 1'b0);
						held = c;
					end else begin
						add_token(KIND_NUMBER, held, 1'b1);
						begin_token(c);
					end
				end
				MODE_OPER: begin
					if (is_op(c)) begin
						add_token(KIND_OPER, held, 1'b0);
						held = c;
					end else begin
						add_token(KIND_OPER, held, 1'b1);
						begin_token(c);
					end
				end
				MODE_SIGN: begin
					if (is_digit(c)) begin
						add_token(KIND_NUMBER, held, 1'b0);
						held = c;
						mode = MODE_NUMBER;
					end else if (is_op(c)) begin
						add_token(KIND_OPER, held, 1'b0);
						held = c;
						mode = MODE_OPER;
					end else begin
						add_token(KIND_OPER, held, 1'b1);
						begin_token(c);
					end
				end
				MODE_WORD: begin
					if (is_letter(c)) begin
						if (int'(nletters) < WordMax) begin
							letters[nletters] = c;
							nletters++;
						end else begin
							overlong = 1'b1;
						end
					end else if (close_word()) begin
						begin_token(c);
					end
				end
				MODE_DISCARD: ;
				default: begin_token(c);
			endcase
		end
		foreach (burst[i]) begin
			r          = burst[i];
			r.run_last = (i == burst.size() - 1);
			expected_tokens.push_back(r);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode     = MODE_IDLE;
			held     = 8'h00;
			nletters = 3'd0;
			overlong = 1'b0;
			foreach (letters[i])
				letters[i] = 8'h00;
			expected_tokens.delete();
			mismatches = 0;
			fail_count <= 0;
			open_count <= 0;
		end else begin
			if (char_valid && !char_stall)
				predict_tokens(char_item);
			if (tok_valid && !tok_stall) begin
				if (expected_tokens.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected token kind %0d char %02h last %0b run %0b",
							$time, tok_item.token_kind, tok_item.text_char,
							tok_item.token_last, tok_item.run_last);
					mismatches++;
				end else begin
					want = expected_tokens.pop_front();
					if (tok_item.token_kind !== want.token_kind ||
							tok_item.text_char !== want.text_char ||
							tok_item.token_last !== want.token_last ||
							tok_item.run_last !== want.run_last) begin
						if (mismatches < 10)
							$display({"%0t: token mismatch: expected kind %0d char %02h ",
								"last %0b run %0b, got kind %0d char %02h last %0b run %0b"},
								$time, want.token_kind, want.text_char, want.token_last,
								want.run_last, tok_item.token_kind, tok_item.text_char,
								tok_item.token_last, tok_item.run_last);
						mismatches++;
					end
				end
			end
			fail_count <= mismatches;
			open_count <= expected_tokens.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
module tb;
	import et_pkg::*;

	localparam int QuietLimit  = 1000;  // cycles with no item moving on either side
	localparam int HoldCycles  = 80;    // long output hold-off, fills the command queue
	localparam int TailCycles  = 40;    // drain time after the last expected token
	localparam int RandomItems = 140;
	localparam int PhaseTwoAt  = 60;    // item counts where the idling pattern changes
	localparam int PhaseThreeAt = 115;
	localparam int HoldAt      = 130;

	logic      clk        = 1'b0;
	logic      arst_n     = 1'b0;
	logic      char_valid = 1'b0;
	in_item_t  char_item  = '0;
	logic      tok_stall  = 1'b0;
	logic      hold_req   = 1'b0;
	logic      char_stall;
	logic      tok_valid;
	out_item_t tok_item;
	int        fail_count;
	int        open_count;

	int send_idle_pct = 29;
	int recv_idle_pct = 86;
	int sent          = 0;
	int useful        = 0;
	int quiet         = 0;
	bit tail_noise    = 1'b0;
	bit hold_done     = 1'b0;

	always #6 clk = ~clk;

	expression_tokenizer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item),
		.tok_valid  (tok_valid),
		.tok_stall  (tok_stall),
		.tok_item   (tok_item)
	);

	token_checker u_token_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item),
		.tok_valid  (tok_valid),
		.tok_stall  (tok_stall),
		.tok_item   (tok_item),
		.fail_count (fail_count),
		.open_count (open_count)
	);

	function automatic bit roll(input int pct);
		return $urandom_range(99, 0) < pct;
	endfunction

	function automatic logic [7:0] pick(input string chars);
		return chars[$urandom_range(chars.len() - 1, 0)];
	endfunction

	// Offer one item and hold it until the block takes it. Idle cycles come
	// before the item, so valid never depends on stall and a stalled item
	// stays put.
	task automatic offer(input in_item_t it);
		while (roll(send_idle_pct)) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_item  <= it;
		@(posedge clk);
		while (char_stall)
			@(posedge clk);
		sent++;
		if (!tail_noise)
			useful++;
		// Swap the idling sides, then stop idling, then ask for the long hold-off.
		if (sent == PhaseTwoAt) begin
			send_idle_pct = 86;
			recv_idle_pct <= 29;
		end else if (sent == PhaseThreeAt) begin
			send_idle_pct = 0;
			recv_idle_pct <= 0;
		end else if (sent == HoldAt) begin
			hold_req <= 1'b1;
		end
	endtask

	task automatic send_char(input logic [7:0] c);
		in_item_t it;
		it.char_code   = c;
		it.end_of_text = 1'b0;
		offer(it);
	endtask

	// End of text; the character field is don't-care, so randomize it.
	task automatic send_end();
		in_item_t it;
		it.char_code   = 8'($urandom_range(255, 0));
		it.end_of_text = 1'b1;
		offer(it);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	task automatic send_space();
		send_char($urandom_range(3, 0) == 0 ? 8'd32 : 8'($urandom_range(13, 9)));
	endtask

	// One expression built from plausible tokens, with an occasional bad word,
	// bad symbol or raw byte. After an error the block only discards, so add a
	// short tail of junk that does not count as useful stimulus.
	task automatic gen_expression();
		int ntok;
		int choice;
		bit spoiled;
		ntok    = $urandom_range(8, 1);
		spoiled = 1'b0;
		for (int t = 0; t < ntok && !spoiled; t++) begin
			choice = $urandom_range(99, 0);
			if (choice < 30) begin
				// optional sign, then a digit and a run of number characters
				if ($urandom_range(3, 0) == 0)
					send_char(pick("+-"));
				send_char(pick("0123456789"));
				repeat ($urandom_range(3, 0))
					send_char(pick("0123456789012345.+-"));
			end else if (choice < 42) begin
				send_char("(");
			end else if (choice < 54) begin
				send_char(")");
			end else if (choice < 74) begin
				repeat ($urandom_range(3, 1))
					send_char(pick("+-*/^<>=!&|"));
			end else if (choice < 88) begin
				if ($urandom_range(1, 0) == 1)
					send_text("true");
				else
					send_text("false");
				// keep the boolean from gluing onto a following word
				send_space();
			end else if (choice < 93) begin
				repeat ($urandom_range(7, 1))
					send_char(pick("abcdefghijklmnopqrstuvwxyzTRUEFALS"));
				spoiled = 1'b1;
			end else if (choice < 97) begin
				case ($urandom_range(2, 0))
					0: send_char(pick("#$%@~;:,?_[]{}"));
					1: send_char(8'($urandom_range(255, 127)));
					default: send_char(8'h00);
				endcase
				spoiled = 1'b1;
			end else begin
				send_char(8'($urandom_range(255, 0)));
			end
			if ($urandom_range(1, 0) == 1)
				repeat ($urandom_range(2, 1))
					send_space();
		end
		if (spoiled) begin
			tail_noise = 1'b1;
			repeat ($urandom_range(3, 0))
				send_char(8'($urandom_range(255, 0)));
			tail_noise = 1'b0;
		end
		// now and then run straight into the next expression
		if ($urandom_range(9, 0) != 0)
			send_end();
	endtask

	// Output side: random stall per cycle, except for one long hold-off that
	// lets the queue fill while the input keeps offering items.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				tok_stall <= 1'b1;
				repeat (HoldCycles)
					@(posedge clk);
			end else begin
				tok_stall <= roll(recv_idle_pct);
			end
		end
	end

	// Count cycles in which nothing moves on either channel.
	always @(posedge clk) begin
		if (!arst_n || (char_valid && !char_stall) || (tok_valid && !tok_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
	end

	// Watchdog: a stuck handshake ends the run.
	initial begin
		do
			@(posedge clk);
		while (quiet < QuietLimit);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sign before a digit; '.' and '+' inside a number; number flushed by end.
		send_text("-7.+");
		send_end();
		// Both parentheses, a boolean, a sign joining an operator run that
		// is flushed by end.
		send_text("(true)|-");
		send_end();
		// Sign before a letter is an operator; overlong word closed by end
		// gives only the bad word.
		send_text("-falsey");
		send_end();
		// NUL flushes the pending number and is itself a bad symbol, 0xFF is discarded,
		// end while discarding yields nothing.
		send_char("9");
		send_char(8'h00);
		send_char(8'hFF);
		send_end();

		useful = 0;
		while (useful < RandomItems)
			gen_expression();
		char_valid <= 1'b0;

		// Drain: wait for every expected token, then give stragglers a chance.
		@(posedge clk);
		while (open_count != 0)
			@(posedge clk);
		repeat (TailCycles)
			@(posedge clk);

		if (fail_count == 0 && open_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/et_pkg.sv
rtl/et_front.sv
rtl/et_queue.sv
rtl/et_back.sv
rtl/expression_tokenizer.sv
rtl/expression_tokenizer_chk.sv
bench/token_checker.sv
bench/tb.sv
